### sv/mmp_pkg.sv
// Shared types and constants for the modular 3x3 matrix power block.
`default_nettype none
package mmp_pkg;

	localparam int ELEM_W    = 24;
	localparam int SUM_W     = ELEM_W + 2;
	localparam int POWER_W   = 31;
	localparam int CHAIN_LEN = ELEM_W;

	// Modulus and its small multiples for the per-bit reduction
	localparam logic [ELEM_W-1:0] MODULUS = 24'd10000007;
	localparam logic [SUM_W-1:0]  MOD_X1  = SUM_W'(10000007);
	localparam logic [SUM_W-1:0]  MOD_X2  = SUM_W'(2 * 10000007);
	localparam logic [SUM_W-1:0]  MOD_X3  = SUM_W'(3 * 10000007);
	localparam logic [SUM_W-1:0]  MOD_X4  = SUM_W'(4 * 10000007);

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [2:0][2:0][ELEM_W-1:0] mat_t;

	// Product tags: running result times base, or base squared
	typedef enum logic {
		TAG_RB = 1'b0,
		TAG_BB = 1'b1
	} tag_t;

	// Data moving from one cell to the next
	typedef struct packed {
		logic                  vld;
		tag_t                  tag;
		elem_t                 acc;
		logic [2:0][ELEM_W-1:0] a;
		logic [2:0][ELEM_W-1:0] b;
	} cell_bus_t;

endpackage
`default_nettype wire

### sv/mmp_cell.sv
// One bit step of a modular three-term dot product.
`default_nettype none
module mmp_cell import mmp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  cell_bus_t      din,
	output cell_bus_t      dout
);

	logic [SUM_W-1:0] sum;
	elem_t            red;

	logic                   vld_q;
	tag_t                   tag_q;
	elem_t                  acc_q;
	logic [2:0][ELEM_W-1:0] a_q;
	logic [2:0][ELEM_W-1:0] b_q;

	// Double the accumulator, add the multiplicands selected by the top multiplier bits, then reduce
	always_comb begin
		sum = {1'b0, din.acc, 1'b0};
		for (int j = 0; j < 3; j++) begin
			if (din.b[j][ELEM_W-1]) begin
				sum = sum + {2'b00, din.a[j]};
			end
		end
		if (sum >= MOD_X4) begin
			red = ELEM_W'(sum - MOD_X4);
		end else if (sum >= MOD_X3) begin
			red = ELEM_W'(sum - MOD_X3);
		end else if (sum >= MOD_X2) begin
			red = ELEM_W'(sum - MOD_X2);
		end else if (sum >= MOD_X1) begin
			red = ELEM_W'(sum - MOD_X1);
		end else begin
			red = ELEM_W'(sum);
		end
	end

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tag_q <= TAG_RB;
		end else begin
			vld_q <= din.vld;
			tag_q <= din.tag;
		end
	end

	// Payload: register the reduced accumulator, pass multiplicands, shift multipliers up one bit
	always_ff @(posedge clk) begin
		acc_q <= red;
		a_q   <= din.a;
		for (int j = 0; j < 3; j++) begin
			b_q[j] <= {din.b[j][ELEM_W-2:0], 1'b0};
		end
	end

	assign dout = '{vld: vld_q, tag: tag_q, acc: acc_q, a: a_q, b: b_q};

endmodule
`default_nettype wire

### sv/mmp_lane.sv
// Chain of bit cells computing one matrix entry as a modular dot product.
`default_nettype none
module mmp_lane import mmp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       vld,
	input  tag_t            tag,
	input  wire logic [2:0][ELEM_W-1:0] a,
	input  wire logic [2:0][ELEM_W-1:0] b,
	output cell_bus_t       res
);

	cell_bus_t link [CHAIN_LEN+1];

	// Feed the first cell with a cleared accumulator
	assign link[0] = '{vld: vld, tag: tag, acc: '0, a: a, b: b};

	for (genvar n = 0; n < CHAIN_LEN; n++) begin : g_cell
		mmp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[n]),
			.dout   (link[n+1])
		);
	end

	assign res = link[CHAIN_LEN];

endmodule
`default_nettype wire

### sv/modular_matrix_power_3x3_top.sv
// Top level: 3x3 matrix power modulo a fixed modulus by square-and-multiply.
//
// Channel | Direction | Payload
// s_axis  | in        | nine base entries (24 b each, row-major) then power (31 b)
// m_axis  | out       | nine result entries (24 b each, row-major)
//
// Each exponent bit issues two matrix products (R*B, B*B) into nine 24-cell lanes,
// one product per cycle, and waits for both to leave the lanes; this repeats
// up to the highest set bit of power; power zero skips the lanes.
// The lane depth (one cell per multiplier bit) sets the wait per bit.
// One item is worked at a time; a finished result waits in an output register
// while the next item is accepted. Reset clears control state only.
`default_nettype none
module modular_matrix_power_3x3_top import mmp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// base_r0c0..base_r2c2 [215:0], power [246:216], pad [247]
	input  wire logic [247:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_r0c0..out_r2c2 [215:0]
	output logic [215:0]      m_axis_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE_RB,
		ST_ISSUE_BB,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t             state_q;
	mat_t               r_q;
	mat_t               b_q;
	mat_t               out_q;
	logic [POWER_W-1:0] pwr_q;
	logic               m_valid_q;

	mat_t               b_in;
	mat_t               b_red;
	mat_t               x_mat;
	mat_t               prod;
	logic               issue_vld;
	tag_t               issue_tag;
	logic               out_free;
	logic [POWER_W-1:0] pwr_next;
	cell_bus_t          lane_res [9];

	// Unpack the base and reduce each entry once
	always_comb begin
		b_in = mat_t'(s_axis_tdata[215:0]);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				b_red[i][j] = (b_in[i][j] >= MODULUS) ? b_in[i][j] - MODULUS : b_in[i][j];
			end
		end
	end

	// Select the left operand for the product being issued
	assign issue_vld = (state_q == ST_ISSUE_RB) || (state_q == ST_ISSUE_BB);
	assign issue_tag = (state_q == ST_ISSUE_BB) ? TAG_BB : TAG_RB;
	assign x_mat     = (issue_tag == TAG_BB) ? b_q : r_q;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			mmp_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.vld    (issue_vld),
				.tag    (issue_tag),
				.a      (x_mat[i]),
				.b      ({b_q[2][k], b_q[1][k], b_q[0][k]}),
				.res    (lane_res[i*3+k])
			);
			assign prod[i][k] = lane_res[i*3+k].acc;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign pwr_next      = pwr_q >> 1;

	// Sequence exponent bits and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			pwr_q     <= '0;
		end else begin
			m_valid_q <= (m_valid_q && !m_axis_tready) || (state_q == ST_FINISH && out_free);
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						pwr_q   <= s_axis_tdata[246:216];
						state_q <= (s_axis_tdata[246:216] == '0) ? ST_FINISH : ST_ISSUE_RB;
					end
				end
				ST_ISSUE_RB: state_q <= ST_ISSUE_BB;
				ST_ISSUE_BB: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (lane_res[0].vld && lane_res[0].tag == TAG_BB) begin
						pwr_q   <= pwr_next;
						state_q <= (pwr_next == '0) ? ST_FINISH : ST_ISSUE_RB;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Matrix registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			b_q <= b_red;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_q[i][j] <= (i == j) ? elem_t'(1) : elem_t'(0);
				end
			end
		end
		if (state_q == ST_WAIT && lane_res[0].vld) begin
			if (lane_res[0].tag == TAG_RB) begin
				if (pwr_q[0]) begin
					r_q <= prod;
				end
			end else begin
				b_q <= prod;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= r_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	// No product leaves the lanes outside the wait state
	a_lane_idle: assert property (@(posedge clk) disable iff (!arst_n)
		lane_res[0].vld |-> state_q == ST_WAIT)
		else $error("lane result outside wait state");

	// Finishing only with the exponent used up
	a_finish_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> pwr_q == '0)
		else $error("finish with exponent bits left");

	// Delivered diagonal entries and entry r0c2 are reduced
	a_out_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_q[0][0] < MODULUS) && (out_q[1][1] < MODULUS)
			&& (out_q[2][2] < MODULUS) && (out_q[0][2] < MODULUS))
		else $error("unreduced result entry");

endmodule
`default_nettype wire

### dv/modular_matrix_power_3x3_checker.sv
// Checker for the modular 3x3 matrix power block: predicts each result and compares it.
`default_nettype none
module modular_matrix_power_3x3_checker import mmp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [247:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [215:0] m_axis_tdata,
	output int                fail_count,
	output int                pending_count
);

	typedef logic [63:0] wide_t;
	typedef wide_t mat9_t [9];

	logic [215:0] power_results[$];

	// Multiply two matrices with every entry reduced by the modulus
	function automatic void mod_mat_mul(input mat9_t x, input mat9_t y, output mat9_t r);
		wide_t m;
		wide_t acc;
		m = 64'(MODULUS);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				acc = '0;
				for (int j = 0; j < 3; j++) begin
					acc = (acc + ((x[i*3+j] % m) * (y[j*3+k] % m)) % m) % m;
				end
				r[i*3+k] = acc;
			end
		end
	endfunction

	// Raise the base to the given power by square-and-multiply
	function automatic logic [215:0] matrix_power(input logic [247:0] d);
		mat9_t base;
		mat9_t acc;
		mat9_t t;
		logic [POWER_W-1:0] p;
		logic [215:0] o;
		for (int i = 0; i < 9; i++) begin
			base[i] = 64'(d[i*ELEM_W +: ELEM_W]);
			acc[i]  = (i % 4 == 0) ? 64'd1 : 64'd0;
		end
		p = d[216 +: POWER_W];
		while (p != 0) begin
			if (p[0]) begin
				mod_mat_mul(acc, base, t);
				acc = t;
			end
			p = p >> 1;
			mod_mat_mul(base, base, t);
			base = t;
		end
		for (int i = 0; i < 9; i++) o[i*ELEM_W +: ELEM_W] = acc[i][ELEM_W-1:0];
		return o;
	endfunction

	assign pending_count = power_results.size();

	// Predict on each input transaction, compare on each output transaction
	always @(posedge clk or negedge arst_n) begin
		logic [215:0] want;
		if (!arst_n) begin
			fail_count = 0;
			power_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				power_results.push_back(matrix_power(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (power_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = power_results.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (want[i*ELEM_W +: ELEM_W] !== m_axis_tdata[i*ELEM_W +: ELEM_W]) begin
							$display("%0t: out entry %0d expected %0d actual %0d", $time, i,
								want[i*ELEM_W +: ELEM_W], m_axis_tdata[i*ELEM_W +: ELEM_W]);
							fail_count++;
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### dv/modular_matrix_power_3x3_top_test.sv
// Testbench top for the modular 3x3 matrix power block: stimulus and verdict.
`default_nettype none
module modular_matrix_power_3x3_top_test;
	import mmp_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [247:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [215:0] m_axis_tdata;
	int           fail_count;
	int           pending_count;
	bit           stim_done = 1'b0;

	modular_matrix_power_3x3_top u_dut (.*);

	modular_matrix_power_3x3_checker u_chk (.*);

	always #4 clk = ~clk;

	// Pick a gap length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [23:0] rand_entry(input int mode);
		case (mode)
			0: return 24'($urandom_range(0, 3));
			1: return MODULUS - 24'($urandom_range(1, 3));
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 10000006));
		endcase
	endfunction

	// Send one matrix and exponent as one transaction
	task automatic send_item(input logic [215:0] b, input logic [30:0] p, input logic z);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, p, b};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [215:0] fill(input int mode);
		logic [215:0] b;
		for (int i = 0; i < 9; i++) b[i*24 +: 24] = rand_entry(mode);
		return b;
	endfunction

	function automatic logic [30:0] rand_power();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 31'($urandom_range(0, 63));
		if (r < 8) return 31'($urandom) >> $urandom_range(0, 30);
		return 31'($urandom);
	endfunction

	// Toggle the result-side ready with random stalls
	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(0, 99) < 70) || (gap_len() == 0);
	end

	initial begin
		logic [215:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: identity power, extremes, unreduced entries, all-ones bits
		send_item({9{24'hFFFFFF}}, 31'd0, 1'b0);
		send_item('0, 31'd0, 1'b1);
		send_item('0, 31'd1, 1'b0);
		send_item(fill(1), 31'd1, 1'b0);
		send_item(fill(1), 31'd2, 1'b0);
		send_item({9{24'hFFFFFF}}, 31'd1, 1'b0);
		send_item({9{24'hFFFFFF}}, 31'h7FFFFFFF, 1'b0);
		send_item(fill(1), 31'h7FFFFFFF, 1'b0);
		send_item(fill(3), 31'h40000000, 1'b0);
		send_item(fill(3), 31'h55555555, 1'b0);
		send_item(fill(3), 31'h2AAAAAAA, 1'b1);
		send_item({9{24'd1}}, 31'd30, 1'b0);
		b = '0;
		b[0 +: 24] = 24'd1; b[96 +: 24] = 24'd1; b[192 +: 24] = 24'd1;
		send_item(b, 31'h7FFFFFFF, 1'b0);
		send_item(fill(0), 31'd5, 1'b0);
		send_item(fill(2), 31'd3, 1'b0);
		// Random part
		repeat (1200) send_item(fill($urandom_range(0, 3)), rand_power(), 1'($urandom));
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Wait for all results, then decide
	initial begin
		wait (stim_done);
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(8 * 6000000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
